// ----- src/rtbrs_pkg.sv -----
// shared constants and types for the rank then binary radix sorter
`timescale 1ns / 1ps

package rtbrs_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 7;

  // commands from the sequencer to the rank unit
  typedef struct packed {
    logic load;
    logic go;
  } rtbrs_ctl_t;

endpackage

// ----- src/rtbrs_rank.sv -----
// value and rank stores with a single shared comparator that ranks every stored value
`timescale 1ns / 1ps

module rtbrs_rank #(
  parameter int MAX_ITEMS = rtbrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rtbrs_pkg::rtbrs_ctl_t                ctl,
  input  logic [$clog2(MAX_ITEMS)-1:0]         wr_addr,
  input  logic signed [rtbrs_pkg::VALUE_W-1:0] wr_data,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]       n,
  input  logic [$clog2(MAX_ITEMS)-1:0]         rd_addr,
  output logic                                 done,
  output logic signed [rtbrs_pkg::VALUE_W-1:0] rd_value,
  output logic [$clog2(MAX_ITEMS+1)-1:0]       rd_rank
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] RS_IDLE  = 3'd0;
  localparam logic [2:0] RS_FETCH = 3'd1;
  localparam logic [2:0] RS_HOLD  = 3'd2;
  localparam logic [2:0] RS_SCAN  = 3'd3;
  localparam logic [2:0] RS_DRAIN = 3'd4;

  logic signed [rtbrs_pkg::VALUE_W-1:0] value_mem [MAX_ITEMS];
  logic [CNT_W-1:0]                     rank_mem  [MAX_ITEMS];

  logic [2:0]                           rstate;
  logic [CNT_W-1:0]                     ri;
  logic [CNT_W-1:0]                     rj;
  logic [CNT_W-1:0]                     cnt;
  logic [CNT_W-1:0]                     cnt_next;
  logic                                 cmp_vld;
  logic                                 inc;
  logic [IDX_W-1:0]                     raddr;
  logic signed [rtbrs_pkg::VALUE_W-1:0] vq;
  logic signed [rtbrs_pkg::VALUE_W-1:0] vi;
  logic [CNT_W-1:0]                     rank_q;
  logic [CNT_W-1:0]                     n_m1;

  assign n_m1 = n - CNT_W'(1);

  // value port is shared: the scan owns it while ranking
  always_comb begin
    case (rstate)
      RS_FETCH: raddr = ri[IDX_W-1:0];
      RS_SCAN:  raddr = rj[IDX_W-1:0];
      default:  raddr = rd_addr;
    endcase
  end

  assign inc      = cmp_vld && (vq <= vi);
  assign cnt_next = cnt + CNT_W'(inc);
  assign done     = (rstate == RS_DRAIN) && (ri == n_m1);
  assign rd_value = vq;
  assign rd_rank  = rank_q;

  always_ff @(posedge clk) begin
    vq     <= value_mem[raddr];
    rank_q <= rank_mem[rd_addr];
    if (ctl.load) begin
      value_mem[wr_addr] <= wr_data;
    end
    if (rstate == RS_DRAIN) begin
      rank_mem[ri[IDX_W-1:0]] <= cnt_next;
    end
    if (rstate == RS_HOLD) begin
      vi <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate  <= RS_IDLE;
      ri      <= '0;
      rj      <= '0;
      cnt     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      case (rstate)
        RS_IDLE: begin
          if (ctl.go) begin
            ri     <= '0;
            rstate <= RS_FETCH;
          end
        end
        RS_FETCH: begin
          rstate <= RS_HOLD;
        end
        RS_HOLD: begin
          rj      <= '0;
          cnt     <= '0;
          cmp_vld <= 1'b0;
          rstate  <= RS_SCAN;
        end
        RS_SCAN: begin
          // the compare sees the value read for the previous scan address
          cnt     <= cnt_next;
          cmp_vld <= 1'b1;
          rj      <= rj + CNT_W'(1);
          if (rj == n_m1) begin
            rstate <= RS_DRAIN;
          end
        end
        RS_DRAIN: begin
          cmp_vld <= 1'b0;
          if (ri == n_m1) begin
            rstate <= RS_IDLE;
          end else begin
            ri     <= ri + CNT_W'(1);
            rstate <= RS_FETCH;
          end
        end
        default: begin
          rstate <= RS_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/rank_then_binary_radix_sort.sv -----
// top level: load sequencer, order and aux stores, radix passes and result output
// loading accepts items while busy is low; after the item marked last the block stays busy
//   ranking, running P radix passes and emitting results, P = bit length of n
// the single rank comparator dominates the busy time: n compares per item, n = items stored
// results leave one per cycle on result_valid; the receiver cannot stall
// reset clears the sequencer, item count and drop flag; the stores hold no reset value
`timescale 1ns / 1ps

module rank_then_binary_radix_sort #(
  parameter int MAX_ITEMS = rtbrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rtbrs_pkg::VALUE_W-1:0] value,
  input  logic                                 last,
  output logic                                 busy,
  output logic                                 result_valid,
  output logic signed [rtbrs_pkg::VALUE_W-1:0] sorted_value,
  output logic [rtbrs_pkg::RANK_W-1:0]         rank,
  output logic                                 final_res,
  output logic                                 overflow
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int BIT_W = $clog2(CNT_W + 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_RANKGO   = 4'd1;
  localparam logic [3:0] S_RANKWAIT = 4'd2;
  localparam logic [3:0] S_INIT     = 4'd3;
  localparam logic [3:0] S_SPLIT    = 4'd4;
  localparam logic [3:0] S_SDRAIN   = 4'd5;
  localparam logic [3:0] S_MERGE    = 4'd6;
  localparam logic [3:0] S_MWAIT    = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_EDRAIN   = 4'd9;

  logic [IDX_W-1:0]                     order_mem [MAX_ITEMS];
  logic [IDX_W-1:0]                     aux_mem   [MAX_ITEMS];

  logic [3:0]                           state;
  logic [CNT_W-1:0]                     count;
  logic                                 dropped;
  logic [CNT_W-1:0]                     k;
  logic [CNT_W-1:0]                     zeros;
  logic [CNT_W-1:0]                     ones;
  logic [BIT_W-1:0]                     b;
  logic [BIT_W-1:0]                     b_plus;
  logic                                 p1_vld;
  logic                                 p1_last;
  logic                                 p2_vld;
  logic                                 p2_last;
  logic [IDX_W-1:0]                     p2_slot;
  logic                                 m_vld;
  logic [IDX_W-1:0]                     m_k;
  logic                                 m_src;

  logic                                 accept;
  logic                                 issue;
  logic                                 k_last;
  logic [CNT_W-1:0]                     count_m1;
  logic [CNT_W-1:0]                     merge_sub;
  logic                                 k_ge_z;
  logic                                 more_passes;
  logic [CNT_W-1:0]                     rank_shift;
  logic                                 rank_bit;
  logic                                 split_wr;
  logic                                 emit_out;
  logic [IDX_W-1:0]                     order_raddr;
  logic [IDX_W-1:0]                     order_q;
  logic [IDX_W-1:0]                     aux_q;

  rtbrs_pkg::rtbrs_ctl_t                ctl;
  logic                                 rank_done;
  logic signed [rtbrs_pkg::VALUE_W-1:0] rd_value;
  logic [CNT_W-1:0]                     rd_rank;
  logic [CNT_W+rtbrs_pkg::RANK_W-1:0]   rank_wide;

  assign busy        = (state != S_LOAD);
  assign accept      = start && (state == S_LOAD);
  assign issue       = (state == S_SPLIT) || (state == S_EMIT);
  assign count_m1    = count - CNT_W'(1);
  assign k_last      = (k == count_m1);
  assign merge_sub   = k - zeros;
  assign k_ge_z      = (k >= zeros);
  assign b_plus      = b + BIT_W'(1);
  assign more_passes = ((count >> b_plus) != '0);
  assign rank_shift  = rd_rank >> b;
  assign rank_bit    = rank_shift[0];
  assign split_wr    = p2_vld && ((state == S_SPLIT) || (state == S_SDRAIN));
  assign emit_out    = p2_vld && ((state == S_EMIT) || (state == S_EDRAIN));
  assign order_raddr = (state == S_MERGE) ? merge_sub[IDX_W-1:0] : k[IDX_W-1:0];

  assign ctl.load = accept && (count < CNT_W'(MAX_ITEMS));
  assign ctl.go   = (state == S_RANKGO);

  rtbrs_rank #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_rank (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (value),
    .n       (count),
    .rd_addr (order_q),
    .done    (rank_done),
    .rd_value(rd_value),
    .rd_rank (rd_rank)
  );

  assign rank_wide    = {{rtbrs_pkg::RANK_W{1'b0}}, rd_rank};
  assign rank         = rank_wide[rtbrs_pkg::RANK_W-1:0];
  assign sorted_value = rd_value;
  assign result_valid = emit_out;
  assign final_res    = p2_last;
  assign overflow     = dropped;

  // order store has one write port shared by init, split and merge
  always_ff @(posedge clk) begin
    order_q <= order_mem[order_raddr];
    aux_q   <= aux_mem[k[IDX_W-1:0]];
    if (state == S_INIT) begin
      order_mem[k[IDX_W-1:0]] <= k[IDX_W-1:0];
    end else if (split_wr && rank_bit) begin
      order_mem[ones[IDX_W-1:0]] <= p2_slot;
    end else if (m_vld) begin
      order_mem[m_k] <= m_src ? order_q : aux_q;
    end
    if (split_wr && !rank_bit) begin
      aux_mem[zeros[IDX_W-1:0]] <= p2_slot;
    end
    p2_slot <= order_q;
    m_k     <= k[IDX_W-1:0];
    m_src   <= k_ge_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      k       <= '0;
      zeros   <= '0;
      ones    <= '0;
      b       <= '0;
      p1_vld  <= 1'b0;
      p1_last <= 1'b0;
      p2_vld  <= 1'b0;
      p2_last <= 1'b0;
      m_vld   <= 1'b0;
    end else begin
      p1_vld  <= issue;
      p1_last <= issue && k_last;
      p2_vld  <= p1_vld;
      p2_last <= p1_last;
      m_vld   <= (state == S_MERGE);
      if (split_wr) begin
        if (rank_bit) begin
          ones <= ones + CNT_W'(1);
        end else begin
          zeros <= zeros + CNT_W'(1);
        end
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (ctl.load) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              state <= S_RANKGO;
            end
          end
        end
        S_RANKGO: begin
          state <= S_RANKWAIT;
        end
        S_RANKWAIT: begin
          if (rank_done) begin
            k     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            k     <= '0;
            b     <= '0;
            zeros <= '0;
            ones  <= '0;
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            state <= S_SDRAIN;
          end
        end
        S_SDRAIN: begin
          if (p2_vld && p2_last) begin
            k     <= count_m1;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          // walk down so each one is read from its old place before that place is overwritten
          k <= k - CNT_W'(1);
          if (k == '0) begin
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          k     <= '0;
          zeros <= '0;
          ones  <= '0;
          if (more_passes) begin
            b     <= b_plus;
            state <= S_SPLIT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            state <= S_EDRAIN;
          end
        end
        S_EDRAIN: begin
          if (p2_vld && p2_last) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the rank then binary radix sorter
`timescale 1ns / 1ps

module testbench;
  import rtbrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int END_SETTLE     = 20;
  localparam int RAND_ITEMS     = 185;
  localparam int MAX_PRINTS     = 40;

  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic [RANK_W-1:0]         rnk;
    logic                      fin;
    logic                      ovf;
  } sorted_t;

  // directed row: typed rows are single-item sets whose result is obvious
  typedef struct packed {
    logic signed [VALUE_W-1:0] v;
    logic                      l;
    logic                      typed;
    logic signed [VALUE_W-1:0] tv;
    logic [RANK_W-1:0]         tr;
  } row_t;

  localparam int N_ROWS = 24;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{INT_MAX, 1'b1, 1'b1, INT_MAX, 7'd1},
    '{INT_MIN, 1'b1, 1'b1, INT_MIN, 7'd1},
    '{32'sd0,  1'b1, 1'b1, 32'sd0,  7'd1},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1, 7'd1},
    // descending set
    '{32'sd5,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd0,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{-32'sd5, 1'b1, 1'b0, 32'sd0, 7'd0},
    // already ascending, the sort still runs all its passes
    '{-32'sd3, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd7,  1'b1, 1'b0, 32'sd0, 7'd0},
    // all equal, shared rank
    '{32'sd9,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd9,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd9,  1'b1, 1'b0, 32'sd0, 7'd0},
    // extremes of both signs
    '{INT_MAX, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{INT_MIN, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd0,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{-32'sd1, 1'b1, 1'b0, 32'sd0, 7'd0},
    // interleaved duplicates
    '{32'sd4,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{-32'sd2, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd4,  1'b0, 1'b0, 32'sd0, 7'd0},
    '{-32'sd2, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{32'sd4,  1'b1, 1'b0, 32'sd0, 7'd0},
    '{INT_MIN, 1'b0, 1'b0, 32'sd0, 7'd0},
    '{INT_MAX, 1'b1, 1'b0, 32'sd0, 7'd0}
  };

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  logic                      busy;
  logic                      result_valid;
  logic signed [VALUE_W-1:0] sorted_value;
  logic [RANK_W-1:0]         rank;
  logic                      final_res;
  logic                      overflow;

  rank_then_binary_radix_sort u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .last         (last),
    .busy         (busy),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .rank         (rank),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sorter state mirrored by the predictor
  logic signed [VALUE_W-1:0] held_vals [MAX_ITEMS_DEF];
  int                        held_count;
  bit                        held_dropped;

  sorted_t pending_sorted [$];
  sorted_t want;
  int      errors;
  int      n_items;
  int      n_sets;
  int      n_results;
  int      n_overflow_sets;
  int      largest_set;
  int      idle_cycles;

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, exp_v);
  endtask

  // store one item; on the last item rank, radix sort and, when emit is set, queue the sorted results
  function automatic void load_value(input logic signed [VALUE_W-1:0] v, input logic l,
                                     input bit emit);
    int      ranks [MAX_ITEMS_DEF];
    int      order [MAX_ITEMS_DEF];
    int      zero_list [MAX_ITEMS_DEF];
    int      one_list [MAX_ITEMS_DEF];
    int      n;
    int      passes;
    int      n_zero;
    int      n_one;
    int      slot;
    int      cnt;
    bit      in_order;
    sorted_t r;
    if (held_count < MAX_ITEMS_DEF) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!l) return;
    n = held_count;
    n_sets++;
    if (held_dropped) n_overflow_sets++;
    if (n > largest_set) largest_set = n;
    passes = 0;
    while ((n >> passes) != 0) passes++;
    for (int i = 0; i < n; i++) begin
      order[i] = i;
      cnt = 0;
      for (int j = 0; j < n; j++)
        if (held_vals[j] <= held_vals[i]) cnt++;
      ranks[i] = cnt;
    end
    for (int b = 0; b < passes; b++) begin
      n_zero = 0;
      n_one  = 0;
      for (int i = 0; i < n; i++) begin
        slot = order[i];
        if (ranks[slot][b]) begin
          one_list[n_one] = slot;
          n_one++;
        end else begin
          zero_list[n_zero] = slot;
          n_zero++;
        end
      end
      for (int i = 0; i < n_zero; i++) order[i] = zero_list[i];
      for (int i = 0; i < n_one; i++) order[n_zero + i] = one_list[i];
      in_order = 1'b1;
      for (int i = 0; i + 1 < n; i++)
        if (held_vals[order[i]] > held_vals[order[i + 1]]) in_order = 1'b0;
      if (in_order) break;
    end
    if (emit) begin
      for (int k = 0; k < n; k++) begin
        slot  = order[k];
        r.val = held_vals[slot];
        r.rnk = ranks[slot][RANK_W-1:0];
        r.fin = (k + 1 == n);
        r.ovf = held_dropped;
        pending_sorted.push_back(r);
      end
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // start stays high across back-to-back items; lowered only for a gap
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l, input bit emit,
                           input int gap);
    start <= 1'b1;
    value <= v;
    last  <= l;
    do @(posedge clk); while (busy);
    load_value(v, l, emit);
    n_items++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      n_results++;
      if (pending_sorted.size() == 0) begin
        report_mismatch("unexpected result value", sorted_value, 0);
      end else begin
        want = pending_sorted.pop_front();
        if (sorted_value !== want.val) report_mismatch("sorted_value", sorted_value, want.val);
        if (rank !== want.rnk)         report_mismatch("rank", rank, want.rnk);
        if (final_res !== want.fin)    report_mismatch("final_res", final_res, want.fin);
        if (overflow !== want.ovf)     report_mismatch("overflow", overflow, want.ovf);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int                        set_idx;
    int                        set_size;
    int                        rand_items;
    int                        mode;
    int                        acc;
    bit                        burst;
    logic signed [VALUE_W-1:0] v;
    rst             = 1'b1;
    start           = 1'b0;
    value           = '0;
    last            = 1'b0;
    held_count      = 0;
    held_dropped    = 1'b0;
    errors          = 0;
    n_items         = 0;
    n_sets          = 0;
    n_results       = 0;
    n_overflow_sets = 0;
    largest_set     = 0;
    idle_cycles     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      // queue a typed result first, its sort can finish within the gap after the item
      if (DIRECTED[i].typed)
        pending_sorted.push_back(sorted_t'{val: DIRECTED[i].tv, rnk: DIRECTED[i].tr,
                                           fin: 1'b1, ovf: 1'b0});
      send_item(DIRECTED[i].v, DIRECTED[i].l, !DIRECTED[i].typed, pick_gap(1'b0));
    end

    // hold off until the directed results are all back
    start <= 1'b0;
    wait_drained();

    set_idx    = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (set_idx == 2)
        set_size = MAX_ITEMS_DEF;
      else if (set_idx == 5)
        set_size = MAX_ITEMS_DEF + $urandom_range(1, 3);
      else if ($urandom_range(0, 3) == 0)
        set_size = $urandom_range(7, 16);
      else
        set_size = $urandom_range(1, 6);
      if (set_size >= MAX_ITEMS_DEF) begin
        start <= 1'b0;
        wait_drained();
      end
      mode  = $urandom_range(0, 3);
      burst = ($urandom_range(0, 3) == 0);
      acc   = $urandom_range(0, 1000) - 500;
      for (int i = 0; i < set_size; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = $signed($urandom_range(0, 8)) - 4;
          2: begin
            case ($urandom_range(0, 4))
              0: v = INT_MIN;
              1: v = INT_MAX;
              2: v = 0;
              3: v = -1;
              default: v = $urandom;
            endcase
          end
          default: begin
            // non-decreasing run, ties allowed
            v = acc;
            acc = acc + $urandom_range(0, 3);
          end
        endcase
        send_item(v, i == set_size - 1, 1'b1, pick_gap(burst));
      end
      set_idx++;
      rand_items += set_size;
    end

    start <= 1'b0;
    last  <= 1'b0;
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch("results never seen", 0, pending_sorted.size());

    $display("sent %0d items in %0d sets, checked %0d sorted results", n_items, n_sets,
             n_results);
    $display("%0d sets over capacity, largest set held %0d items", n_overflow_sets,
             largest_set);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rtbrs_pkg.sv
src/rtbrs_rank.sv
src/rank_then_binary_radix_sort.sv
tb/sv/testbench.sv
